### sv/kct_pkg.sv
`default_nettype none
package kct_pkg;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] measurement;
    logic signed [31:0] control_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_accel;
    logic signed [31:0] predicted_position;
  } out_t;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SEED   = 2'd2;
  // unassigned code, runs as a plain update
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [2:0] CFG_TIME_STEP      = 3'd0;
  localparam logic [2:0] CFG_PROCESS_NOISE  = 3'd1;
  localparam logic [2:0] CFG_MEASURE_NOISE  = 3'd2;
  localparam logic [2:0] CFG_LOOKAHEAD_TIME = 3'd3;
  localparam logic [2:0] CFG_CONTROL_SCALE  = 3'd4;

  // operand and destination codes of the shared multiply-accumulate path
  typedef enum logic [5:0] {
    OP_ZERO, OP_ONE, OP_DT, OP_Q, OP_R, OP_LA, OP_CS, OP_Z, OP_CTRL,
    OP_X0, OP_X1, OP_X2,
    OP_P00, OP_P01, OP_P02, OP_P10, OP_P11, OP_P12, OP_P20, OP_P21, OP_P22,
    OP_T00, OP_T01, OP_T02, OP_T10, OP_T11, OP_T12,
    OP_K0, OP_K1, OP_K2,
    OP_Y, OP_S, OP_INV, OP_U1, OP_U, OP_H, OP_HT, OP_PRED
  } opnd_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    opnd_t add;
    opnd_t dst;
    logic  start;
    logic  neg;
    logic  half;
    logic  wr;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic seed;
    logic mul;
    logic acc;
    logic div_start;
    logic load;
    uop_t uop;
  } ctl_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_DIV  = 6'd31;
  localparam logic [PC_W-1:0] PC_PRED = 6'd47;
  localparam logic [PC_W-1:0] PC_END  = 6'd50;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input opnd_t a, input opnd_t b, input opnd_t add,
                              input opnd_t dst, input logic start, input logic neg,
                              input logic half, input logic wr);
    uop_t u;
    u.a = a; u.b = b; u.add = add; u.dst = dst;
    u.start = start; u.neg = neg; u.half = half; u.wr = wr;
    return u;
  endfunction

  // microprogram: predict, covariance predict, innovation variance, gain,
  // correction, lookahead
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_DT,   OP_DT,   OP_ZERO, OP_H,    1'b1, 1'b0, 1'b1, 1'b1);
      6'd1:  u = mk(OP_CTRL, OP_DT,   OP_ZERO, OP_U1,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd2:  u = mk(OP_U1,   OP_CS,   OP_ZERO, OP_U,    1'b1, 1'b0, 1'b0, 1'b1);
      6'd3:  u = mk(OP_DT,   OP_X1,   OP_X0,   OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd4:  u = mk(OP_H,    OP_X2,   OP_ZERO, OP_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      6'd5:  u = mk(OP_U,    OP_ONE,  OP_ZERO, OP_X0,   1'b0, 1'b0, 1'b0, 1'b1);
      6'd6:  u = mk(OP_DT,   OP_X2,   OP_X1,   OP_X1,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd7:  u = mk(OP_DT,   OP_P10,  OP_P00,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd8:  u = mk(OP_H,    OP_P20,  OP_ZERO, OP_T00,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd9:  u = mk(OP_DT,   OP_P11,  OP_P01,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd10: u = mk(OP_H,    OP_P21,  OP_ZERO, OP_T01,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd11: u = mk(OP_DT,   OP_P12,  OP_P02,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd12: u = mk(OP_H,    OP_P22,  OP_ZERO, OP_T02,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd13: u = mk(OP_DT,   OP_P20,  OP_P10,  OP_T10,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd14: u = mk(OP_DT,   OP_P21,  OP_P11,  OP_T11,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd15: u = mk(OP_DT,   OP_P22,  OP_P12,  OP_T12,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd16: u = mk(OP_DT,   OP_T01,  OP_T00,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd17: u = mk(OP_H,    OP_T02,  OP_ZERO, OP_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      6'd18: u = mk(OP_Q,    OP_ONE,  OP_ZERO, OP_P00,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd19: u = mk(OP_DT,   OP_T02,  OP_T01,  OP_P01,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd20: u = mk(OP_ZERO, OP_ZERO, OP_T02,  OP_P02,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd21: u = mk(OP_DT,   OP_T11,  OP_T10,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd22: u = mk(OP_H,    OP_T12,  OP_ZERO, OP_P10,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd23: u = mk(OP_DT,   OP_T12,  OP_T11,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd24: u = mk(OP_Q,    OP_ONE,  OP_ZERO, OP_P11,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd25: u = mk(OP_ZERO, OP_ZERO, OP_T12,  OP_P12,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd26: u = mk(OP_DT,   OP_P21,  OP_P20,  OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd27: u = mk(OP_H,    OP_P22,  OP_ZERO, OP_P20,  1'b0, 1'b0, 1'b0, 1'b1);
      6'd28: u = mk(OP_DT,   OP_P22,  OP_P21,  OP_P21,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd29: u = mk(OP_Q,    OP_ONE,  OP_P22,  OP_P22,  1'b1, 1'b0, 1'b0, 1'b1);
      6'd30: u = mk(OP_P00,  OP_ONE,  OP_R,    OP_S,    1'b1, 1'b0, 1'b0, 1'b1);
      6'd31: u = mk(OP_P00,  OP_INV,  OP_ZERO, OP_K0,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd32: u = mk(OP_P10,  OP_INV,  OP_ZERO, OP_K1,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd33: u = mk(OP_P20,  OP_INV,  OP_ZERO, OP_K2,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd34: u = mk(OP_X0,   OP_ONE,  OP_Z,    OP_Y,    1'b1, 1'b1, 1'b0, 1'b1);
      6'd35: u = mk(OP_K0,   OP_Y,    OP_X0,   OP_X0,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd36: u = mk(OP_K1,   OP_Y,    OP_X1,   OP_X1,   1'b1, 1'b0, 1'b0, 1'b1);
      6'd37: u = mk(OP_K2,   OP_Y,    OP_X2,   OP_X2,   1'b1, 1'b0, 1'b0, 1'b1);
      // row zero of the covariance is read by every row, so it goes last
      6'd38: u = mk(OP_K1,   OP_P00,  OP_P10,  OP_P10,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd39: u = mk(OP_K1,   OP_P01,  OP_P11,  OP_P11,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd40: u = mk(OP_K1,   OP_P02,  OP_P12,  OP_P12,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd41: u = mk(OP_K2,   OP_P00,  OP_P20,  OP_P20,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd42: u = mk(OP_K2,   OP_P01,  OP_P21,  OP_P21,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd43: u = mk(OP_K2,   OP_P02,  OP_P22,  OP_P22,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd44: u = mk(OP_K0,   OP_P00,  OP_P00,  OP_P00,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd45: u = mk(OP_K0,   OP_P01,  OP_P01,  OP_P01,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd46: u = mk(OP_K0,   OP_P02,  OP_P02,  OP_P02,  1'b1, 1'b1, 1'b0, 1'b1);
      6'd47: u = mk(OP_LA,   OP_LA,   OP_ZERO, OP_HT,   1'b1, 1'b0, 1'b1, 1'b1);
      6'd48: u = mk(OP_LA,   OP_X1,   OP_X0,   OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd49: u = mk(OP_HT,   OP_X2,   OP_ZERO, OP_PRED, 1'b0, 1'b0, 1'b0, 1'b1);
      default: u = mk(OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### sv/kalman_const_accel_tracker.sv
// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_stall   | kct_pkg::in_t  (cmd, measurement, control_in)
// out_     | output    | out_valid / out_stall | kct_pkg::out_t (state, predicted position)
// cfg_     | input     | cfg_we                | cfg_index selects, cfg_data (31 bits)
//
// one transaction at a time through a single 32x32 multiply-accumulate unit,
// each microprogram step a multiply state then an accumulate state; an update
// runs the whole microprogram, a clear-only command only its lookahead steps
// the reciprocal of the innovation variance comes from a one-bit-per-cycle divider
// reset is synchronous, active low; state clears to zero, covariance to identity
// a finished result waits in the output register while the next transaction is taken
`default_nettype none
module kalman_const_accel_tracker #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire kct_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output kct_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [30:0]   cfg_data
);

  kct_pkg::ctl_t ctl;
  kct_pkg::sts_t sts;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  kct_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### sv/kct_div.sv
`default_nettype none
module kct_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] s,
  output logic                    done,
  output logic signed [31:0]      inv
);

  localparam int NW = 2 * FRAC_BITS + 2;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]     num_r, num_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       mag_r, mag_nxt;
  logic signed [31:0] inv_r, inv_nxt;

  logic [31:0] mag_in;
  logic [32:0] rem2;
  logic        ge;
  logic [63:0] q64;

  always_comb begin
    mag_in   = s[31] ? (32'd0 - s) : s;
    rem2     = {rem_r, num_r[NW-1]};
    ge       = rem2 >= {1'b0, mag_r};
    q64      = {{(64-NW){1'b0}}, num_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    mag_nxt  = mag_r;
    inv_nxt  = inv_r;
    if (start) begin
      if (s == 32'sd0) begin
        inv_nxt  = ONE_Q;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        neg_nxt  = s[31];
        mag_nxt  = mag_in;
        rem_nxt  = 32'd0;
        cnt_nxt  = CW'(NW);
        num_nxt  = (NW'(1) << (2 * FRAC_BITS)) + NW'(mag_in >> 1);
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        // one quotient bit per cycle, restoring
        rem_nxt = ge ? 32'(rem2 - {1'b0, mag_r}) : rem2[31:0];
        num_nxt = {num_r[NW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!neg_r) inv_nxt = (q64 > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q64[31:0];
        else inv_nxt = (q64 > 64'h80000000) ? 32'sh80000000 : (32'd0 - q64[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    mag_r <= mag_nxt;
    inv_r <= inv_nxt;
  end

  assign done = done_r;
  assign inv  = inv_r;

endmodule
`default_nettype wire

### sv/kct_datapath.sv
`default_nettype none
module kct_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire kct_pkg::in_t    in_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [30:0]     cfg_data,
  input  wire kct_pkg::ctl_t   ctl,
  output kct_pkg::sts_t        sts,
  output kct_pkg::out_t        out_data
);

  localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] BIAS_F = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] BIAS_H = 64'sd1 <<< FRAC_BITS;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic [30:0] DT_RST = 31'((ONE_L * 25 + 500) / 1000);
  localparam logic [30:0] Q_RST  = 31'((ONE_L + 5) / 10);
  localparam logic [30:0] R_RST  = 31'((ONE_L * 5 + 50) / 100);
  localparam logic [30:0] LA_RST = 31'(ONE_L / 2);
  localparam logic [30:0] CS_RST = 31'(ONE_L * 15);

  logic [30:0] dt_r, q_r, r_r, la_r, cs_r;
  logic signed [31:0] z_r, ctrl_r;
  logic signed [31:0] x_r [0:2];
  logic signed [31:0] p_r [0:8];
  logic signed [31:0] t_r [0:5];
  logic signed [31:0] k_r [0:2];
  logic signed [31:0] y_r, s_r, u1_r, u_r, h_r, ht_r, pred_r;
  logic signed [63:0] prod_r, acc_r;
  kct_pkg::out_t      out_r;

  logic signed [31:0] inv;
  logic               div_done;
  logic signed [31:0] va, vb, vadd, wval;
  logic signed [63:0] rnd, base, accv;

  kct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .s     (s_r),
    .done  (div_done),
    .inv   (inv)
  );

  function automatic logic signed [31:0] rd(input kct_pkg::opnd_t sel);
    logic signed [31:0] v;
    case (sel)
      kct_pkg::OP_ONE:  v = ONE_Q;
      kct_pkg::OP_DT:   v = {1'b0, dt_r};
      kct_pkg::OP_Q:    v = {1'b0, q_r};
      kct_pkg::OP_R:    v = {1'b0, r_r};
      kct_pkg::OP_LA:   v = {1'b0, la_r};
      kct_pkg::OP_CS:   v = {1'b0, cs_r};
      kct_pkg::OP_Z:    v = z_r;
      kct_pkg::OP_CTRL: v = ctrl_r;
      kct_pkg::OP_X0:   v = x_r[0];
      kct_pkg::OP_X1:   v = x_r[1];
      kct_pkg::OP_X2:   v = x_r[2];
      kct_pkg::OP_P00:  v = p_r[0];
      kct_pkg::OP_P01:  v = p_r[1];
      kct_pkg::OP_P02:  v = p_r[2];
      kct_pkg::OP_P10:  v = p_r[3];
      kct_pkg::OP_P11:  v = p_r[4];
      kct_pkg::OP_P12:  v = p_r[5];
      kct_pkg::OP_P20:  v = p_r[6];
      kct_pkg::OP_P21:  v = p_r[7];
      kct_pkg::OP_P22:  v = p_r[8];
      kct_pkg::OP_T00:  v = t_r[0];
      kct_pkg::OP_T01:  v = t_r[1];
      kct_pkg::OP_T02:  v = t_r[2];
      kct_pkg::OP_T10:  v = t_r[3];
      kct_pkg::OP_T11:  v = t_r[4];
      kct_pkg::OP_T12:  v = t_r[5];
      kct_pkg::OP_K0:   v = k_r[0];
      kct_pkg::OP_K1:   v = k_r[1];
      kct_pkg::OP_K2:   v = k_r[2];
      kct_pkg::OP_Y:    v = y_r;
      kct_pkg::OP_S:    v = s_r;
      kct_pkg::OP_INV:  v = inv;
      kct_pkg::OP_U1:   v = u1_r;
      kct_pkg::OP_U:    v = u_r;
      kct_pkg::OP_H:    v = h_r;
      kct_pkg::OP_HT:   v = ht_r;
      kct_pkg::OP_PRED: v = pred_r;
      default:          v = 32'sd0;
    endcase
    return v;
  endfunction

  always_comb begin
    va   = rd(ctl.uop.a);
    vb   = rd(ctl.uop.b);
    vadd = rd(ctl.uop.add);
    // product rounded half up; the half-square form drops one more bit
    if (ctl.uop.half) rnd = (prod_r + BIAS_H) >>> (FRAC_BITS + 1);
    else rnd = (prod_r + BIAS_F) >>> FRAC_BITS;
    base = ctl.uop.start ? {{32{vadd[31]}}, vadd} : acc_r;
    accv = ctl.uop.neg ? (base - rnd) : (base + rnd);
    wval = kct_pkg::sat32(accv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RST;
      q_r  <= Q_RST;
      r_r  <= R_RST;
      la_r <= LA_RST;
      cs_r <= CS_RST;
      for (int i = 0; i < 3; i++) x_r[i] <= 32'sd0;
      for (int i = 0; i < 9; i++) p_r[i] <= (i % 4 == 0) ? ONE_Q : 32'sd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kct_pkg::CFG_TIME_STEP:      dt_r <= cfg_data;
          kct_pkg::CFG_PROCESS_NOISE:  q_r  <= cfg_data;
          kct_pkg::CFG_MEASURE_NOISE:  r_r  <= cfg_data;
          kct_pkg::CFG_LOOKAHEAD_TIME: la_r <= cfg_data;
          kct_pkg::CFG_CONTROL_SCALE:  cs_r <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.clear) begin
        // a seed command puts the measurement in place of the cleared position
        x_r[0] <= ctl.seed ? z_r : 32'sd0;
        x_r[1] <= 32'sd0;
        x_r[2] <= 32'sd0;
        for (int i = 0; i < 9; i++) p_r[i] <= (i % 4 == 0) ? ONE_Q : 32'sd0;
      end
      if (ctl.acc && ctl.uop.wr) begin
        case (ctl.uop.dst)
          kct_pkg::OP_X0:  x_r[0] <= wval;
          kct_pkg::OP_X1:  x_r[1] <= wval;
          kct_pkg::OP_X2:  x_r[2] <= wval;
          kct_pkg::OP_P00: p_r[0] <= wval;
          kct_pkg::OP_P01: p_r[1] <= wval;
          kct_pkg::OP_P02: p_r[2] <= wval;
          kct_pkg::OP_P10: p_r[3] <= wval;
          kct_pkg::OP_P11: p_r[4] <= wval;
          kct_pkg::OP_P12: p_r[5] <= wval;
          kct_pkg::OP_P20: p_r[6] <= wval;
          kct_pkg::OP_P21: p_r[7] <= wval;
          kct_pkg::OP_P22: p_r[8] <= wval;
          default: ;
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      z_r    <= in_data.measurement;
      ctrl_r <= in_data.control_in;
    end
    if (ctl.mul) prod_r <= va * vb;
    if (ctl.acc) begin
      acc_r <= accv;
      if (ctl.uop.wr) begin
        case (ctl.uop.dst)
          kct_pkg::OP_T00:  t_r[0] <= wval;
          kct_pkg::OP_T01:  t_r[1] <= wval;
          kct_pkg::OP_T02:  t_r[2] <= wval;
          kct_pkg::OP_T10:  t_r[3] <= wval;
          kct_pkg::OP_T11:  t_r[4] <= wval;
          kct_pkg::OP_T12:  t_r[5] <= wval;
          kct_pkg::OP_K0:   k_r[0] <= wval;
          kct_pkg::OP_K1:   k_r[1] <= wval;
          kct_pkg::OP_K2:   k_r[2] <= wval;
          kct_pkg::OP_Y:    y_r    <= wval;
          kct_pkg::OP_S:    s_r    <= wval;
          kct_pkg::OP_U1:   u1_r   <= wval;
          kct_pkg::OP_U:    u_r    <= wval;
          kct_pkg::OP_H:    h_r    <= wval;
          kct_pkg::OP_HT:   ht_r   <= wval;
          kct_pkg::OP_PRED: pred_r <= wval;
          default: ;
        endcase
      end
    end
    if (ctl.load) begin
      out_r.est_position       <= x_r[0];
      out_r.est_velocity       <= x_r[1];
      out_r.est_accel          <= x_r[2];
      out_r.predicted_position <= pred_r;
    end
  end

  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule
`default_nettype wire

### sv/kct_ctrl.sv
`default_nettype none
module kct_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_cmd,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire kct_pkg::sts_t sts,
  output kct_pkg::ctl_t      ctl
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_MUL, ST_ACC, ST_DIV_START, ST_DIV_WAIT, ST_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [kct_pkg::PC_W-1:0]    pc_r, pc_nxt, pc_inc;
  logic [1:0]                  cmd_r, cmd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept, load;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign pc_inc = pc_r + 1'b1;
  assign load   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        pc_nxt    = (cmd_r == kct_pkg::CMD_CLEAR) ? kct_pkg::PC_PRED : '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        pc_nxt = pc_inc;
        if (pc_inc == kct_pkg::PC_DIV) state_nxt = ST_DIV_START;
        else if (pc_inc == kct_pkg::PC_END) state_nxt = ST_FIN;
        else state_nxt = ST_MUL;
      end
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_MUL;
      end
      ST_FIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      cmd_r       <= kct_pkg::CMD_UPDATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl.capture   = accept;
    ctl.clear     = (state_r == ST_INIT) &&
                    (cmd_r == kct_pkg::CMD_CLEAR || cmd_r == kct_pkg::CMD_SEED);
    ctl.seed      = (state_r == ST_INIT) && (cmd_r == kct_pkg::CMD_SEED);
    ctl.mul       = (state_r == ST_MUL);
    ctl.acc       = (state_r == ST_ACC);
    ctl.div_start = (state_r == ST_DIV_START);
    ctl.load      = load;
    ctl.uop       = kct_pkg::prog(pc_r);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_INIT)
    else $error("accepted transaction did not start");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= kct_pkg::PC_END)
    else $error("microprogram counter out of range");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside of wait");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while held");

endmodule
`default_nettype wire

### tb/kalman_const_accel_tracker_test.sv
`default_nettype none
module kalman_const_accel_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LIMIT = 2_000_000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  kct_pkg::in_t in_data;
  kct_pkg::out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  kalman_const_accel_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tracker copy: registers and filter state
  longint dt_q, qn_q, rn_q, la_q, cs_q;
  longint xv[3];
  longint pc[3][3];

  kct_pkg::out_t estimates[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_clear = 0, n_seed = 0;
  longint cycles = 0;
  bit hold_long = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // signed product rounded half up to the fraction width
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return (p + (64'sd1 << (FB - 1))) >>> FB;
  endfunction

  function automatic longint half_square(input longint t);
    longint p;
    p = t * t;
    return sat((p + (64'sd1 << FB)) >>> (FB + 1));
  endfunction

  function automatic void filter_clear();
    for (int i = 0; i < 3; i++) begin
      xv[i] = 0;
      for (int j = 0; j < 3; j++) pc[i][j] = (i == j) ? ONE : 0;
    end
  endfunction

  function automatic void filter_update(input longint z, input longint ctl);
    longint f[3][3];
    longint t1[3][3];
    longint xn[3];
    longint pn[3][3];
    longint g[3];
    longint acc, s, inv, y, u, mag, qt;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) f[i][j] = (i == j) ? ONE : 0;
    f[0][1] = dt_q;
    f[1][2] = dt_q;
    f[0][2] = half_square(dt_q);
    u = sat(qmul(sat(qmul(ctl, dt_q)), cs_q));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += qmul(f[i][k], xv[k]);
      if (i == 0) acc += u;
      xn[i] = sat(acc);
    end
    xv = xn;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += qmul(f[i][k], pc[k][j]);
        t1[i][j] = sat(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += qmul(t1[i][k], f[j][k]);
        if (i == j) acc += qn_q;
        pc[i][j] = sat(acc);
      end
    s = sat(pc[0][0] + rn_q);
    if (s == 0) inv = ONE;
    else begin
      mag = (s < 0) ? -s : s;
      qt = ((64'sd1 << (2 * FB)) + mag / 2) / mag;
      if (s > 0) inv = (qt > 64'sd2147483647) ? 64'sd2147483647 : qt;
      else inv = (qt > 64'sd2147483648) ? -64'sd2147483648 : -qt;
    end
    for (int i = 0; i < 3; i++) g[i] = sat(qmul(pc[i][0], inv));
    y = sat(z - xv[0]);
    for (int i = 0; i < 3; i++) xv[i] = sat(xv[i] + qmul(g[i], y));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) pn[i][j] = sat(pc[i][j] - qmul(g[i], pc[0][j]));
    pc = pn;
  endfunction

  function automatic kct_pkg::out_t track_step(input kct_pkg::in_t t);
    kct_pkg::out_t r;
    longint pr;
    if (t.cmd == kct_pkg::CMD_CLEAR || t.cmd == kct_pkg::CMD_SEED) filter_clear();
    if (t.cmd == kct_pkg::CMD_SEED) xv[0] = longint'(t.measurement);
    if (t.cmd != kct_pkg::CMD_CLEAR)
      filter_update(longint'(t.measurement), longint'(t.control_in));
    pr = xv[0] + qmul(la_q, xv[1]) + qmul(half_square(la_q), xv[2]);
    r.est_position = xv[0][31:0];
    r.est_velocity = xv[1][31:0];
    r.est_accel = xv[2][31:0];
    r.predicted_position = sat(pr);
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kct_pkg::CFG_TIME_STEP: dt_q = val;
      kct_pkg::CFG_PROCESS_NOISE: qn_q = val;
      kct_pkg::CFG_MEASURE_NOISE: rn_q = val;
      kct_pkg::CFG_LOOKAHEAD_TIME: la_q = val;
      kct_pkg::CFG_CONTROL_SCALE: cs_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high across back-to-back transactions, drops only for a gap or a drain
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input kct_pkg::in_t t, input bit typed, input kct_pkg::out_t want);
    kct_pkg::out_t e;
    idle_gap();
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = track_step(t);
    if (typed && e !== want)
      $display("%0t directed row mismatch in predictor: expected %h got %h", $time, want, e);
    estimates.push_back(typed ? want : e);
    n_sent++;
    if (t.cmd == kct_pkg::CMD_CLEAR) n_clear++;
    if (t.cmd == kct_pkg::CMD_SEED) n_seed++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (estimates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    kct_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_recv++;
      if (estimates.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = estimates.pop_front();
        if (out_data.est_position !== e.est_position) begin
          $display("%0t est_position expected %h actual %h", $time, e.est_position,
                   out_data.est_position);
          errors++;
        end
        if (out_data.est_velocity !== e.est_velocity) begin
          $display("%0t est_velocity expected %h actual %h", $time, e.est_velocity,
                   out_data.est_velocity);
          errors++;
        end
        if (out_data.est_accel !== e.est_accel) begin
          $display("%0t est_accel expected %h actual %h", $time, e.est_accel,
                   out_data.est_accel);
          errors++;
        end
        if (out_data.predicted_position !== e.predicted_position) begin
          $display("%0t predicted_position expected %h actual %h", $time,
                   e.predicted_position, out_data.predicted_position);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [1:0] cmd;
    logic [31:0] meas;
    logic [31:0] ctl;
    bit typed;
    kct_pkg::out_t want;
  } row_t;

  row_t rows[$];

  initial begin
    kct_pkg::in_t t;
    kct_pkg::out_t zero_out;
    logic [30:0] dts[4];
    zero_out = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = kct_pkg::CFG_TIME_STEP;
    cfg_data = '0;
    dt_q = 1638; qn_q = 6554; rn_q = 3277; la_q = 32768; cs_q = 983040;
    filter_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clears read off at once, the rest from the predictor
    rows = '{
      '{kct_pkg::CMD_CLEAR, 32'h12345678, 32'h0, 1'b1, zero_out},
      '{kct_pkg::CMD_UPDATE, 32'h00010000, 32'h0, 1'b0, zero_out},
      '{kct_pkg::CMD_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, zero_out},
      '{kct_pkg::CMD_UPDATE, 32'h80000000, 32'h80000000, 1'b0, zero_out},
      '{kct_pkg::CMD_SEED, 32'h00050000, 32'hFFFF0000, 1'b0, zero_out},
      '{kct_pkg::CMD_SPARE, 32'h00060000, 32'h00010000, 1'b0, zero_out},
      '{kct_pkg::CMD_SEED, 32'h7FFFFFFF, 32'h0, 1'b0, zero_out},
      '{kct_pkg::CMD_UPDATE, 32'h80000000, 32'h7FFFFFFF, 1'b0, zero_out},
      '{kct_pkg::CMD_SEED, 32'h80000000, 32'hFFFFFFFF, 1'b0, zero_out},
      '{kct_pkg::CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, zero_out},
      '{kct_pkg::CMD_UPDATE, 32'h0, 32'h0, 1'b0, zero_out}
    };
    foreach (rows[i]) begin
      t.cmd = rows[i].cmd;
      t.measurement = rows[i].meas;
      t.control_in = rows[i].ctl;
      send_item(t, rows[i].typed, rows[i].want);
    end
    drain();

    // zero innovation variance: r = 0 with covariance driven toward zero
    write_reg(kct_pkg::CFG_MEASURE_NOISE, 31'd0);
    write_reg(kct_pkg::CFG_PROCESS_NOISE, 31'd0);
    write_reg(kct_pkg::CFG_TIME_STEP, 31'd1);
    for (int i = 0; i < 6; i++) begin
      t.cmd = (i == 0) ? kct_pkg::CMD_SEED : kct_pkg::CMD_UPDATE;
      t.measurement = rnd32();
      t.control_in = rnd32();
      send_item(t, 1'b0, zero_out);
    end
    drain();

    // extremes of every register
    write_reg(kct_pkg::CFG_TIME_STEP, 31'h7FFFFFFF);
    write_reg(kct_pkg::CFG_PROCESS_NOISE, 31'h7FFFFFFF);
    write_reg(kct_pkg::CFG_MEASURE_NOISE, 31'h7FFFFFFF);
    write_reg(kct_pkg::CFG_LOOKAHEAD_TIME, 31'h7FFFFFFF);
    write_reg(kct_pkg::CFG_CONTROL_SCALE, 31'h7FFFFFFF);
    for (int i = 0; i < 5; i++) begin
      t.cmd = (i == 0) ? kct_pkg::CMD_SEED : kct_pkg::CMD_UPDATE;
      t.measurement = rnd32();
      t.control_in = rnd32();
      send_item(t, 1'b0, zero_out);
    end
    drain();
    write_reg(kct_pkg::CFG_LOOKAHEAD_TIME, 31'd0);
    write_reg(kct_pkg::CFG_CONTROL_SCALE, 31'd0);

    // random phases over several register settings
    dts[0] = 31'd1638; dts[1] = 31'd1; dts[2] = 31'd65536; dts[3] = 31'h7FFFFFFF;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(kct_pkg::CFG_TIME_STEP, 31'd1638);
        write_reg(kct_pkg::CFG_PROCESS_NOISE, 31'd6554);
        write_reg(kct_pkg::CFG_MEASURE_NOISE, 31'd3277);
        write_reg(kct_pkg::CFG_LOOKAHEAD_TIME, 31'd32768);
        write_reg(kct_pkg::CFG_CONTROL_SCALE, 31'd983040);
      end else begin
        write_reg(kct_pkg::CFG_TIME_STEP, ($urandom_range(0, 1) == 0) ?
                  dts[$urandom_range(0, 3)] : 31'($urandom_range(1, 32'h7FFFFFFF)));
        write_reg(kct_pkg::CFG_PROCESS_NOISE, ($urandom_range(0, 3) == 0) ?
                  31'($urandom) : 31'($urandom_range(0, 65536)));
        write_reg(kct_pkg::CFG_MEASURE_NOISE, ($urandom_range(0, 3) == 0) ?
                  31'($urandom) : 31'($urandom_range(0, 65536)));
        write_reg(kct_pkg::CFG_LOOKAHEAD_TIME, 31'($urandom_range(0, 1) ? $urandom :
                  $urandom_range(0, 131072)));
        write_reg(kct_pkg::CFG_CONTROL_SCALE, 31'($urandom_range(0, 1) ? $urandom :
                  $urandom_range(0, 1048576)));
      end
      if (ph == 2) hold_long = 1;
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(0, 19))
          0: t.cmd = kct_pkg::CMD_CLEAR;
          1: t.cmd = kct_pkg::CMD_SEED;
          2: t.cmd = kct_pkg::CMD_SPARE;
          default: t.cmd = kct_pkg::CMD_UPDATE;
        endcase
        t.measurement = rnd32();
        t.control_in = rnd32();
        send_item(t, 1'b0, zero_out);
      end
      drain();
    end

    $display("sent %0d transactions (%0d clear, %0d seed), checked %0d results",
             n_sent, n_clear, n_seed, n_recv);
    $display("register settings covered defaults, zero noise and full-scale values");
    if (errors == 0 && estimates.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
